// File: rtl/event_zero_suppress_packer_macros.svh
// Assertion helpers used by the checker file.
`ifndef EVENT_ZERO_SUPPRESS_PACKER_MACROS_SVH
`define EVENT_ZERO_SUPPRESS_PACKER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define EZSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define EZSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ezsp_pkg.sv
`default_nettype none
package ezsp_pkg;

  localparam int WORD_W  = 16;
  localparam int LABEL_W = 8;
  localparam int VALUE_W = 15;
  localparam int COUNT_W = 8;
  localparam int PAD_W   = 14;

  localparam logic [1:0] KIND_PAD   = 2'd0;
  localparam logic [1:0] KIND_HEAD  = 2'd1;
  localparam logic [1:0] KIND_ENTRY = 2'd2;
  localparam logic [1:0] KIND_TRAIL = 2'd3;

  localparam logic REQ_WORD  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic signed [WORD_W-1:0] word;
  } ezsp_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COUNT_W-1:0] fired_count;
    logic [LABEL_W-1:0] label;
    logic [VALUE_W-1:0] value;
    logic [PAD_W-1:0]   pad_bytes;
    logic               overflow;
    logic               last;
  } ezsp_out_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [VALUE_W-1:0] value;
  } ezsp_entry_t;

endpackage
`default_nettype wire

// File: rtl/event_zero_suppress_packer.sv
// Channel   Dir  Ports                          Content
// in_       in   in_valid, in_stall, in_data    readout word or end-of-stream flush
// out_      out  out_valid, out_stall, out_data pad, header, entries, trailer
//
// A readout word that ends no event is taken without raising in_stall.
// An event end is accepted, then its results go out in order: pad (if any) and,
// when entries fired, header, n entries, trailer; the sequencer issues one result
// per cycle while out_stall is low, through one output register and the entry RAM's read port.
// Reset is synchronous and clears control state; the entry RAM is not cleared.
// out_stall holds the sequencer; in_stall is high until the last result is loaded.
`default_nettype none
module event_zero_suppress_packer
  import ezsp_pkg::*;
#(
  parameter int MAX_FIRED   = 32,
  parameter int BLOCK_BYTES = 8192
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire ezsp_in_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      ezsp_out_t out_data
);

  localparam int IW     = (MAX_FIRED > 1) ? $clog2(MAX_FIRED) : 1;
  localparam int CW     = $clog2(MAX_FIRED + 1);
  localparam int FW     = $clog2(BLOCK_BYTES);
  localparam int CMP_W  = FW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_ENTRY = 3'd3;
  localparam logic [2:0] S_TRAIL = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      fired_r, fired_nxt;
  logic [LABEL_W-1:0] pos_r, pos_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic               drop_r, drop_nxt;
  logic               flush_r, flush_nxt;
  logic               out_valid_r, out_valid_nxt;
  ezsp_out_t          out_data_r, out_data_nxt;

  ezsp_entry_t        mem [MAX_FIRED];
  ezsp_entry_t        rd_q_r;
  logic               mem_we;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;

  logic               slot_free;
  logic               pad_hit;
  logic [CMP_W-1:0]   need_bytes;
  logic [CMP_W-1:0]   fill_sum;
  logic [CMP_W-1:0]   pad_left;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // block accounting: check before an event, fill after it
  assign need_bytes = CMP_W'(fill_r) + CMP_W'(4) + (CMP_W'(fired_r) << 2);
  assign pad_hit    = (need_bytes >= CMP_W'(BLOCK_BYTES));
  assign fill_sum   = CMP_W'(fill_r) + CMP_W'(2) + (CMP_W'(fired_r) << 1)
                      + CMP_W'(fired_r);
  assign pad_left   = CMP_W'(BLOCK_BYTES) - CMP_W'(fill_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    fired_nxt     = fired_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    flush_nxt     = flush_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == REQ_FLUSH) begin
            flush_nxt = 1'b1;
            if (fired_r != '0) begin
              state_nxt = S_HEAD;
            end else begin
              fill_nxt  = '0;
              pos_nxt   = LABEL_W'(1);
              drop_nxt  = 1'b0;
            end
          end else if (in_data.word[WORD_W-1]) begin
            flush_nxt = 1'b0;
            if (pad_hit) begin
              state_nxt = S_PAD;
            end else if (fired_r != '0) begin
              state_nxt = S_HEAD;
            end else begin
              pos_nxt  = LABEL_W'(1);
              drop_nxt = 1'b0;
            end
          end else begin
            if (in_data.word != '0) begin
              if (fired_r < CW'(MAX_FIRED)) begin
                mem_we    = 1'b1;
                fired_nxt = fired_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            pos_nxt = pos_r + LABEL_W'(1);
          end
        end
      end
      S_PAD: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = '0;
          out_data_nxt.kind      = KIND_PAD;
          out_data_nxt.pad_bytes = pad_left[PAD_W-1:0];
          out_data_nxt.last      = (fired_r == '0);
          fill_nxt               = '0;
          if (fired_r != '0) begin
            state_nxt = S_HEAD;
          end else begin
            state_nxt = S_IDLE;
            pos_nxt   = LABEL_W'(1);
            drop_nxt  = 1'b0;
          end
        end
      end
      S_HEAD: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.kind        = KIND_HEAD;
          out_data_nxt.fired_count = COUNT_W'(fired_r);
          out_data_nxt.overflow    = drop_r;
          rd_en                    = 1'b1;
          rd_addr                  = '0;
          idx_nxt                  = '0;
          state_nxt                = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt          = '0;
          out_data_nxt.kind     = KIND_ENTRY;
          out_data_nxt.label    = rd_q_r.label;
          out_data_nxt.value    = rd_q_r.value;
          out_data_nxt.overflow = drop_r;
          if (CW'(idx_r) + CW'(1) == fired_r) begin
            state_nxt = S_TRAIL;
          end else begin
            // prefetch the next entry while this one goes out
            rd_en   = 1'b1;
            rd_addr = idx_r + IW'(1);
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      S_TRAIL: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.kind        = KIND_TRAIL;
          out_data_nxt.fired_count = COUNT_W'(fired_r);
          out_data_nxt.overflow    = drop_r;
          out_data_nxt.last        = 1'b1;
          fill_nxt                 = flush_r ? '0 : fill_sum[FW-1:0];
          fired_nxt                = '0;
          pos_nxt                  = LABEL_W'(1);
          drop_nxt                 = 1'b0;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fired_r[IW-1:0]] <= '{label: pos_r, value: in_data.word[VALUE_W-1:0]};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      fired_r     <= '0;
      pos_r       <= LABEL_W'(1);
      fill_r      <= '0;
      drop_r      <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fired_r     <= fired_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/ezsp_checker.sv
`default_nettype none
`include "event_zero_suppress_packer_macros.svh"
module ezsp_checker
  import ezsp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire ezsp_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire ezsp_out_t out_data
);

  `EZSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // entries always sit inside an event that is still draining
  `EZSP_ASSERT_NOW(a_entry_busy, out_valid && out_data.kind == KIND_ENTRY, in_stall, "input open during entries")

  `EZSP_ASSERT_NOW(a_pad_clean, out_valid && out_data.kind == KIND_PAD, out_data.fired_count == '0 && out_data.label == '0 && out_data.value == '0 && !out_data.overflow, "pad carries event fields")

  `EZSP_ASSERT_NOW(a_head_not_last, out_valid && out_data.kind == KIND_HEAD, !out_data.last, "header flagged last")

endmodule

bind event_zero_suppress_packer ezsp_checker u_ezsp_checker (.*);
`default_nettype wire
